[hdl/cidp_pkg.sv]
// Shared types, constants and register codes for the caller-ID message parser.
// Used by every module of the block; depends on nothing.
package cidp_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BYTES = 3'd0,
    CFG_SDMF_CODE = 3'd1,
    CFG_MDMF_CODE = 3'd2,
    CFG_DT_CODE   = 3'd3,
    CFG_NUM_CODE  = 3'd4,
    CFG_ABS_CODE  = 3'd5
  } cfg_idx_t;

  localparam logic [8:0] RST_MAX_BYTES = 9'd258;
  localparam logic [7:0] RST_SDMF_CODE = 8'd4;
  localparam logic [7:0] RST_MDMF_CODE = 8'd128;
  localparam logic [7:0] RST_DT_CODE   = 8'd1;
  localparam logic [7:0] RST_NUM_CODE  = 8'd2;
  localparam logic [7:0] RST_ABS_CODE  = 8'd4;

  localparam logic [7:0] CHAR_P         = 8'h50;
  localparam logic [7:0] CHAR_O         = 8'h4F;
  localparam logic [7:0] DT_LEN         = 8'd8;
  localparam logic [8:0] MIN_FRAME      = 9'd3;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;
  localparam logic [8:0] BODY_START     = 9'd2;
  localparam logic [8:0] LEN_POS        = 9'd1;

  typedef enum logic [2:0] {
    ROLE_MSG_TYPE   = 3'd0,
    ROLE_MSG_LEN    = 3'd1,
    ROLE_PARAM_TYPE = 3'd2,
    ROLE_PARAM_LEN  = 3'd3,
    ROLE_PARAM_DATA = 3'd4,
    ROLE_CHECKSUM   = 3'd5,
    ROLE_DISCARD    = 3'd6
  } role_t;

  typedef enum logic [1:0] {
    FMT_UNKNOWN = 2'd0,
    FMT_SDMF    = 2'd1,
    FMT_MDMF    = 2'd2,
    FMT_OTHER   = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic [8:0] max_message_bytes;
    logic [7:0] sdmf_code;
    logic [7:0] mdmf_code;
    logic [7:0] datetime_code;
    logic [7:0] number_code;
    logic [7:0] absence_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      byte_role;
    logic [7:0] param_type;
    logic [7:0] param_length;
    logic       last_of_param;
    logic       message_done;
    logic       checksum_ok;
    logic       format_ok;
    logic       truncated;
  } out_beat_t;

endpackage

[hdl/cidp_cfg.sv]
// Configuration register file of the caller-ID message parser.
// Depends on cidp_pkg for the register codes, reset values and cfg_t.
module cidp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cidp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]                     cfg_data,
  output cidp_pkg::cfg_t                 cfg
);

  cidp_pkg::cfg_t cfg_r;
  cidp_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cidp_pkg::cfg_idx_t'(cfg_index))
        cidp_pkg::CFG_MAX_BYTES: cfg_nxt.max_message_bytes = cfg_data;
        cidp_pkg::CFG_SDMF_CODE: cfg_nxt.sdmf_code         = cfg_data[7:0];
        cidp_pkg::CFG_MDMF_CODE: cfg_nxt.mdmf_code         = cfg_data[7:0];
        cidp_pkg::CFG_DT_CODE:   cfg_nxt.datetime_code     = cfg_data[7:0];
        cidp_pkg::CFG_NUM_CODE:  cfg_nxt.number_code       = cfg_data[7:0];
        cidp_pkg::CFG_ABS_CODE:  cfg_nxt.absence_code      = cfg_data[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_bytes <= cidp_pkg::RST_MAX_BYTES;
      cfg_r.sdmf_code         <= cidp_pkg::RST_SDMF_CODE;
      cfg_r.mdmf_code         <= cidp_pkg::RST_MDMF_CODE;
      cfg_r.datetime_code     <= cidp_pkg::RST_DT_CODE;
      cfg_r.number_code       <= cidp_pkg::RST_NUM_CODE;
      cfg_r.absence_code      <= cidp_pkg::RST_ABS_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/cidp_parse.sv]
// Frame and parameter tracker: message state registers plus the per-byte tagging logic.
// Depends on cidp_pkg for cfg_t, the beat structs, roles, formats and phases.
module cidp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  cidp_pkg::in_beat_t    item,
  input  cidp_pkg::cfg_t        cfg,
  output cidp_pkg::out_beat_t   result
);

  logic [8:0]        pos_r, pos_nxt, pos_c;
  logic [8:0]        fe_r, fe_nxt, fe_c;
  logic [7:0]        blen_r, blen_nxt, blen_c;
  logic [7:0]        sum_r, sum_nxt, sum_c;
  cidp_pkg::fmt_t    fmt_r, fmt_nxt, fmt_c;
  logic              fin_r, fin_nxt, fin_c;
  cidp_pkg::phase_t  phase_r, phase_nxt, phase_c;
  logic [7:0]        cparam_r, cparam_nxt, cparam_c;
  logic [7:0]        prem_r, prem_nxt, prem_c;
  logic [7:0]        pdecl_r, pdecl_nxt, pdecl_c;
  logic              capped_r, capped_nxt, capped_c;

  // restart clears state before this byte is handled
  assign pos_c    = item.restart ? '0 : pos_r;
  assign fe_c     = item.restart ? '0 : fe_r;
  assign blen_c   = item.restart ? '0 : blen_r;
  assign sum_c    = item.restart ? '0 : sum_r;
  assign fmt_c    = item.restart ? cidp_pkg::FMT_UNKNOWN : fmt_r;
  assign fin_c    = item.restart ? 1'b0 : fin_r;
  assign phase_c  = item.restart ? cidp_pkg::PH_TYPE : phase_r;
  assign cparam_c = item.restart ? '0 : cparam_r;
  assign prem_c   = item.restart ? '0 : prem_r;
  assign pdecl_c  = item.restart ? '0 : pdecl_r;
  assign capped_c = item.restart ? 1'b0 : capped_r;

  always_comb begin
    logic [7:0] b;
    logic [8:0] cap_lim;
    logic [8:0] fe_new;
    logic [8:0] off;
    logic [7:0] sum_b;
    logic [7:0] decl;
    logic [7:0] rem;
    logic [7:0] cp;

    b       = item.rx_byte;
    cap_lim = (cfg.max_message_bytes < cidp_pkg::MIN_FRAME) ? cidp_pkg::MIN_FRAME
                                                            : cfg.max_message_bytes;
    fe_new  = {1'b0, b} + cidp_pkg::FRAME_OVERHEAD;
    off     = pos_c - cidp_pkg::BODY_START;
    sum_b   = sum_c + b;
    decl    = pdecl_c;
    rem     = prem_c;
    cp      = cparam_c;

    pos_nxt    = pos_c;
    fe_nxt     = fe_c;
    blen_nxt   = blen_c;
    sum_nxt    = sum_c;
    fmt_nxt    = fmt_c;
    fin_nxt    = fin_c;
    phase_nxt  = phase_c;
    cparam_nxt = cparam_c;
    prem_nxt   = prem_c;
    pdecl_nxt  = pdecl_c;
    capped_nxt = capped_c;

    result               = '0;
    result.out_byte      = b;
    result.byte_role     = cidp_pkg::ROLE_DISCARD;

    if (!fin_c) begin
      pos_nxt = pos_c + 9'd1;
      if (pos_c == '0) begin
        result.byte_role = cidp_pkg::ROLE_MSG_TYPE;
        sum_nxt = b;
        if (b == cfg.sdmf_code) begin
          fmt_nxt = cidp_pkg::FMT_SDMF;
        end else if (b == cfg.mdmf_code) begin
          fmt_nxt = cidp_pkg::FMT_MDMF;
        end else begin
          fmt_nxt = cidp_pkg::FMT_OTHER;
        end
      end else if (pos_c == cidp_pkg::LEN_POS) begin
        result.byte_role = cidp_pkg::ROLE_MSG_LEN;
        sum_nxt  = sum_b;
        blen_nxt = b;
        if (fe_new > cap_lim) begin
          fe_nxt     = cap_lim;
          capped_nxt = 1'b1;
        end else begin
          fe_nxt     = fe_new;
          capped_nxt = 1'b0;
        end
        result.truncated = capped_nxt;
      end else if (({1'b0, pos_c} + 10'd1) >= {1'b0, fe_c}) begin
        result.byte_role    = cidp_pkg::ROLE_CHECKSUM;
        result.message_done = 1'b1;
        result.checksum_ok  = (sum_b == 8'd0);
        result.format_ok    = (fmt_c == cidp_pkg::FMT_SDMF) || (fmt_c == cidp_pkg::FMT_MDMF);
        result.truncated    = capped_c;
        sum_nxt = sum_b;
        fin_nxt = 1'b1;
        pos_nxt = pos_c;
      end else begin
        result.truncated = capped_c;
        sum_nxt = sum_b;
        if (fmt_c == cidp_pkg::FMT_SDMF) begin
          result.byte_role = cidp_pkg::ROLE_PARAM_DATA;
          if (off < {1'b0, cidp_pkg::DT_LEN}) begin
            cparam_nxt = cfg.datetime_code;
            pdecl_nxt  = cidp_pkg::DT_LEN;
            prem_nxt   = '0;
            result.last_of_param = (off == {1'b0, cidp_pkg::DT_LEN - 8'd1});
          end else begin
            if (prem_c == '0) begin
              if ((b == cidp_pkg::CHAR_P) || (b == cidp_pkg::CHAR_O)) begin
                cp   = cfg.absence_code;
                decl = 8'd1;
              end else begin
                cp   = cfg.number_code;
                decl = blen_c - off[7:0];
              end
              rem = decl;
            end
            rem        = rem - 8'd1;
            cparam_nxt = cp;
            pdecl_nxt  = decl;
            prem_nxt   = rem;
            result.last_of_param = (rem == '0);
          end
          result.param_type   = cparam_nxt;
          result.param_length = pdecl_nxt;
        end else if (fmt_c == cidp_pkg::FMT_MDMF) begin
          unique case (phase_c)
            cidp_pkg::PH_TYPE: begin
              result.byte_role  = cidp_pkg::ROLE_PARAM_TYPE;
              result.param_type = b;
              cparam_nxt = b;
              phase_nxt  = cidp_pkg::PH_LEN;
            end
            cidp_pkg::PH_LEN: begin
              result.byte_role    = cidp_pkg::ROLE_PARAM_LEN;
              result.param_type   = cparam_c;
              result.param_length = b;
              pdecl_nxt = b;
              prem_nxt  = b;
              phase_nxt = (b == '0) ? cidp_pkg::PH_TYPE : cidp_pkg::PH_DATA;
            end
            cidp_pkg::PH_DATA: begin
              result.byte_role    = cidp_pkg::ROLE_PARAM_DATA;
              result.param_type   = cparam_c;
              result.param_length = pdecl_c;
              rem      = prem_c - 8'd1;
              prem_nxt = rem;
              if (rem == '0) begin
                result.last_of_param = 1'b1;
                phase_nxt = cidp_pkg::PH_TYPE;
              end
            end
            default: phase_nxt = cidp_pkg::PH_TYPE;
          endcase
        end else begin
          result.byte_role = cidp_pkg::ROLE_PARAM_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fe_r     <= '0;
      blen_r   <= '0;
      sum_r    <= '0;
      fmt_r    <= cidp_pkg::FMT_UNKNOWN;
      fin_r    <= 1'b0;
      phase_r  <= cidp_pkg::PH_TYPE;
      cparam_r <= '0;
      prem_r   <= '0;
      pdecl_r  <= '0;
      capped_r <= 1'b0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      fe_r     <= fe_nxt;
      blen_r   <= blen_nxt;
      sum_r    <= sum_nxt;
      fmt_r    <= fmt_nxt;
      fin_r    <= fin_nxt;
      phase_r  <= phase_nxt;
      cparam_r <= cparam_nxt;
      prem_r   <= prem_nxt;
      pdecl_r  <= pdecl_nxt;
      capped_r <= capped_nxt;
    end
  end

endmodule

[hdl/caller_id_message_parser_core.sv]
// Top level of the caller-ID message parser: input register, parser, result register.
// Depends on cidp_pkg, cidp_cfg and cidp_parse.
//
//   channel   direction  handshake               payload
//   in_       receive    in_valid / in_stall     in_data  (in_beat_t)
//   out_      send       out_valid / out_stall   out_data (out_beat_t)
//   cfg_      receive    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall stays low.
// All tagging for a byte is done between the input register and the result register.
// Synchronous active-low reset clears the message state and loads register defaults.
// A stalled result holds in the result register while the input register still takes a beat;
// in_stall rises only when both registers are full and out_stall is high.
module caller_id_message_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cidp_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cidp_pkg::out_beat_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cidp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]                     cfg_data
);

  cidp_pkg::cfg_t      cfg;
  cidp_pkg::in_beat_t  in_data_r;
  logic                in_valid_r;
  cidp_pkg::out_beat_t result;
  cidp_pkg::out_beat_t out_data_r;
  logic                out_valid_r;
  logic                out_free;
  logic                advance;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cidp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cidp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

[hdl/cidp_checker.sv]
// Port-level checks for the caller-ID message parser, bound to the top level.
// Depends on cidp_pkg for the beat structs and role codes.
module cidp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input cidp_pkg::out_beat_t out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_done |-> out_data.byte_role == cidp_pkg::ROLE_CHECKSUM)
    else $error("message_done on a non-checksum beat");

  a_verdict_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.checksum_ok || out_data.format_ok) |-> out_data.message_done)
    else $error("verdict reported before end of frame");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_role == cidp_pkg::ROLE_DISCARD |->
      out_data.param_type == '0 && out_data.param_length == '0 &&
      !out_data.last_of_param && !out_data.message_done && !out_data.truncated)
    else $error("discarded beat carries tags");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_param |-> out_data.byte_role == cidp_pkg::ROLE_PARAM_DATA)
    else $error("last_of_param outside parameter data");

endmodule

bind caller_id_message_parser_core cidp_checker u_cidp_checker (.*);

[sim/tb.sv]
// Self-checking testbench for caller_id_message_parser_core: framed caller-ID messages in,
// tagged byte beats out, each compared with a cycle-free parser model held in a scoreboard.
// Depends on cidp_pkg and the parser RTL only.
module tb;
  import cidp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class cid_scoreboard;
    cfg_t       regs;
    logic [8:0] pos;
    logic [8:0] frame_end;
    logic [7:0] body_len;
    logic [7:0] sum;
    fmt_t       fmt;
    bit         finished;
    phase_t     mdmf_step;
    logic [7:0] cur_param;
    logic [7:0] remaining;
    logic [7:0] declared;
    bit         capped;
    out_beat_t  expected_q[$];
    int         errors;

    function new();
      regs.max_message_bytes = RST_MAX_BYTES;
      regs.sdmf_code         = RST_SDMF_CODE;
      regs.mdmf_code         = RST_MDMF_CODE;
      regs.datetime_code     = RST_DT_CODE;
      regs.number_code       = RST_NUM_CODE;
      regs.absence_code      = RST_ABS_CODE;
      errors = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      pos = '0;
      frame_end = '0;
      body_len = '0;
      sum = '0;
      fmt = FMT_UNKNOWN;
      finished = 0;
      mdmf_step = PH_TYPE;
      cur_param = '0;
      remaining = '0;
      declared = '0;
      capped = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] d);
      case (cfg_idx_t'(idx))
        CFG_MAX_BYTES: regs.max_message_bytes = d;
        CFG_SDMF_CODE: regs.sdmf_code = d[7:0];
        CFG_MDMF_CODE: regs.mdmf_code = d[7:0];
        CFG_DT_CODE:   regs.datetime_code = d[7:0];
        CFG_NUM_CODE:  regs.number_code = d[7:0];
        CFG_ABS_CODE:  regs.absence_code = d[7:0];
        default: ;
      endcase
    endfunction

    function void note_byte(in_beat_t ib);
      out_beat_t  r;
      logic [7:0] b;
      logic [7:0] tot;
      logic [8:0] cap;
      logic [8:0] off;
      b = ib.rx_byte;
      r = '0;
      r.out_byte = b;
      r.byte_role = ROLE_DISCARD;
      if (ib.restart) clear_msg();
      if (!finished) begin
        if (pos == 9'd0) begin
          r.byte_role = ROLE_MSG_TYPE;
          sum = b;
          if (b == regs.sdmf_code) fmt = FMT_SDMF;
          else if (b == regs.mdmf_code) fmt = FMT_MDMF;
          else fmt = FMT_OTHER;
        end else if (pos == LEN_POS) begin
          cap = (regs.max_message_bytes < MIN_FRAME) ? MIN_FRAME : regs.max_message_bytes;
          r.byte_role = ROLE_MSG_LEN;
          sum = sum + b;
          body_len = b;
          frame_end = {1'b0, b} + FRAME_OVERHEAD;
          capped = 0;
          if (frame_end > cap) begin
            frame_end = cap;
            capped = 1;
          end
          r.truncated = capped;
        end else if ({1'b0, pos} + 10'd1 >= {1'b0, frame_end}) begin
          tot = sum + b;
          r.byte_role = ROLE_CHECKSUM;
          r.message_done = 1'b1;
          r.checksum_ok = (tot == 8'd0);
          r.format_ok = (fmt == FMT_SDMF) || (fmt == FMT_MDMF);
          r.truncated = capped;
          sum = tot;
          finished = 1;
        end else begin
          off = pos - BODY_START;
          r.truncated = capped;
          sum = sum + b;
          if (fmt == FMT_SDMF) begin
            r.byte_role = ROLE_PARAM_DATA;
            if (off < DT_LEN) begin
              cur_param = regs.datetime_code;
              declared = DT_LEN;
              remaining = '0;
              r.last_of_param = (off == DT_LEN - 8'd1);
            end else begin
              if (remaining == 8'd0) begin
                if (b == CHAR_P || b == CHAR_O) begin
                  cur_param = regs.absence_code;
                  declared = 8'd1;
                end else begin
                  cur_param = regs.number_code;
                  declared = body_len - off[7:0];
                end
                remaining = declared;
              end
              remaining = remaining - 8'd1;
              r.last_of_param = (remaining == 8'd0);
            end
            r.param_type = cur_param;
            r.param_length = declared;
          end else if (fmt == FMT_MDMF) begin
            case (mdmf_step)
              PH_TYPE: begin
                r.byte_role = ROLE_PARAM_TYPE;
                cur_param = b;
                r.param_type = b;
                mdmf_step = PH_LEN;
              end
              PH_LEN: begin
                r.byte_role = ROLE_PARAM_LEN;
                r.param_type = cur_param;
                r.param_length = b;
                declared = b;
                remaining = b;
                if (b == 8'd0) mdmf_step = PH_TYPE;
                else mdmf_step = PH_DATA;
              end
              default: begin
                r.byte_role = ROLE_PARAM_DATA;
                r.param_type = cur_param;
                r.param_length = declared;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) begin
                  r.last_of_param = 1'b1;
                  mdmf_step = PH_TYPE;
                end
              end
            endcase
          end else begin
            r.byte_role = ROLE_PARAM_DATA;
          end
        end
        if (!finished) pos = pos + 9'd1;
      end
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string nm, logic [8:0] exp, logic [8:0] got);
      if (got !== exp) begin
        $error("%s: expected %0d, got %0d", nm, exp, got);
        errors++;
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation: out_byte %0d", got.out_byte);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("out_byte", e.out_byte, got.out_byte);
      cmp_field("byte_role", e.byte_role, got.byte_role);
      cmp_field("param_type", e.param_type, got.param_type);
      cmp_field("param_length", e.param_length, got.param_length);
      cmp_field("last_of_param", e.last_of_param, got.last_of_param);
      cmp_field("message_done", e.message_done, got.message_done);
      cmp_field("checksum_ok", e.checksum_ok, got.checksum_ok);
      cmp_field("format_ok", e.format_ok, got.format_ok);
      cmp_field("truncated", e.truncated, got.truncated);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [8:0]           cfg_data;

  cid_scoreboard sb;
  int            send_pct;
  int            recv_pct;
  int            sent_cnt;
  bit            hold_req;

  caller_id_message_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin : result_side
    int hold_cnt;
    hold_cnt = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_cnt = 60;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic rs);
    in_beat_t v;
    v.rx_byte = b;
    v.restart = rs;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_one(cfg_idx_t idx, logic [8:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [8:0] cap, logic [7:0] sd, logic [7:0] md,
                          logic [7:0] dt, logic [7:0] nm, logic [7:0] ab);
    write_one(CFG_MAX_BYTES, cap);
    write_one(CFG_SDMF_CODE, {1'b0, sd});
    write_one(CFG_MDMF_CODE, {1'b0, md});
    write_one(CFG_DT_CODE, {1'b0, dt});
    write_one(CFG_NUM_CODE, {1'b0, nm});
    write_one(CFG_ABS_CODE, {1'b0, ab});
    cfg_valid <= 1'b0;
  endtask

  // Frame length follows the current cap; a short body is padded with random bytes.
  task automatic send_frame(logic [7:0] typ, byte_q_t body, int decl, bit corrupt, int tail);
    int         cap;
    int         nb;
    int         k;
    logic [7:0] ck;
    logic [7:0] d;
    cap = (sb.regs.max_message_bytes < MIN_FRAME) ? 3 : int'(sb.regs.max_message_bytes);
    nb = ((decl + 3 < cap) ? decl + 3 : cap) - 3;
    send_byte(typ, 1'b1);
    ck = typ;
    send_byte(decl[7:0], 1'b0);
    ck = ck + decl[7:0];
    for (k = 0; k < nb; k++) begin
      d = (k < body.size()) ? body[k] : 8'($urandom_range(255));
      send_byte(d, 1'b0);
      ck = ck + d;
    end
    ck = 8'd0 - ck;
    if (corrupt) ck = ck ^ 8'($urandom_range(1, 255));
    send_byte(ck, 1'b0);
    repeat (tail) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_message();
    byte_q_t    body;
    logic [7:0] typ;
    int         sel;
    int         n;
    int         decl;
    int         k;
    sel = $urandom_range(99);
    if (sel < 45) typ = sb.regs.sdmf_code;
    else if (sel < 85) typ = sb.regs.mdmf_code;
    else typ = 8'($urandom_range(255));
    if (typ == sb.regs.sdmf_code) begin
      for (k = 0; k < 8; k++)
        body.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'h30 + 8'($urandom_range(9)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(2) == 0) begin
          body.push_back($urandom_range(1) ? CHAR_P : CHAR_O);
        end else begin
          repeat ($urandom_range(1, 12)) body.push_back(8'h30 + 8'($urandom_range(9)));
        end
      end
      if ($urandom_range(5) == 0) begin
        n = $urandom_range(7);
        while (body.size() > n) void'(body.pop_back());
      end
    end else if (typ == sb.regs.mdmf_code) begin
      repeat ($urandom_range(1, 4)) begin
        body.push_back(8'($urandom_range(255)));
        n = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 10);
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(7) == 0) void'(body.pop_back());
    end else begin
      repeat ($urandom_range(12)) body.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(29) == 0) begin
      n = $urandom_range(200, 255);
      while (body.size() < n) body.push_back(8'($urandom_range(255)));
    end
    decl = body.size();
    if ($urandom_range(9) == 0) decl = $urandom_range(255);
    send_frame(typ, body, decl, $urandom_range(7) == 0,
               ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  task automatic run_phase(logic [8:0] cap, logic [7:0] sd, logic [7:0] md, logic [7:0] dt,
                           logic [7:0] nm, logic [7:0] ab, int s_pct, int r_pct, int budget,
                           bit pressure);
    int stop_at;
    bit pressed;
    wait_empty();
    set_regs(cap, sd, md, dt, nm, ab);
    send_pct = s_pct;
    recv_pct = r_pct;
    stop_at = sent_cnt + budget;
    pressed = 0;
    while (sent_cnt < stop_at) begin
      if (pressure && !pressed && sent_cnt > stop_at - budget / 2) begin
        wait_empty();
        hold_req = 1;
        pressed = 1;
      end
      if ($urandom_range(9) == 0) send_noise();
      else send_message();
    end
  endtask

  initial begin
    byte_q_t body;
    sb = new();
    send_pct = 10;
    recv_pct = 48;
    sent_cnt = 0;
    hold_req = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_BYTES;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // SDMF with absence code, MDMF with a zero-length parameter, unknown type byte
    body = '{8'h30, 8'h31, 8'h30, 8'h31, 8'h31, 8'h32, 8'h33, 8'h30, CHAR_O};
    send_frame(RST_SDMF_CODE, body, body.size(), 1'b0, 1);
    body = '{8'h02, 8'h00, 8'h07, 8'h01, 8'h00};
    send_frame(RST_MDMF_CODE, body, body.size(), 1'b1, 0);
    body = {};
    send_frame(8'hFF, body, 0, 1'b0, 0);

    run_phase(9'd258, 8'd4, 8'd128, 8'd1, 8'd2, 8'd4, 10, 48, 220, 1'b1);
    run_phase(9'd30, 8'h80, 8'h80, 8'hFF, 8'h00, 8'hFF, 10, 48, 180, 1'b0);
    run_phase(9'd3, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 48, 10, 100, 1'b0);
    run_phase(9'd0, 8'h04, 8'h80, 8'h01, 8'h02, 8'h04, 48, 10, 80, 1'b0);
    run_phase(9'd16, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 0, 0, 220, 1'b0);
    run_phase(9'd511, 8'hC0, 8'h04, 8'h55, 8'hAA, 8'h7F, 0, 0, 200, 1'b0);

    wait_empty();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
